FILE: design/sd_spi_init_sequencer_macros.svh
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer_macros
// assertion macros shared by the sd card spi init sequencer files
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_SEQUENCER_MACROS_SVH
`define SD_SPI_INIT_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SDI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdinit check failed");

// next-cycle implication, checked out of reset
`define SDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdinit check failed");

`else

`define SDI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SDI_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/sdinit_pkg.sv
// ----------------------------------------------------------------------------
// sdinit_pkg
// types, codes and precomputed command frames for the sd spi init sequencer
// ----------------------------------------------------------------------------
package sdinit_pkg;

   localparam int unsigned BAUD_W  = 8;
   localparam int unsigned LIMIT_W = 12;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned FRAME_W = 48;
   localparam int unsigned TRAILER_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BAUD_REDUCTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_LIMIT    = 2'd3;

   // register reset values
   localparam logic [BAUD_W-1:0]  BAUD_RESET          = 8'd0;
   localparam logic [LIMIT_W-1:0] RESET_LIMIT_RESET   = 12'd1024;
   localparam logic [LIMIT_W-1:0] VOLTAGE_LIMIT_RESET = 12'd3;
   localparam logic [LIMIT_W-1:0] READY_LIMIT_RESET   = 12'd2500;

   // result status codes
   localparam logic [1:0] STATUS_SEND    = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_FAIL    = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   // input mode codes
   localparam logic MODE_START    = 1'b0;
   localparam logic MODE_RESPONSE = 1'b1;

   localparam logic [BAUD_W-1:0]    SLOW_DIVISOR = 8'd149;
   localparam logic [7:0]           R1_IDLE      = 8'h01;
   localparam logic [TRAILER_W-1:0] VHS_PATTERN  = 32'h0000_01AA;
   localparam logic [TRAILER_W-1:0] HCS_ARG      = 32'h4000_0000;
   localparam logic [TRAILER_W-1:0] BLOCK_LENGTH = 32'd512;
   localparam logic [6:0]           CRC7_POLY    = 7'h09;

   typedef struct packed {
      logic [BAUD_W-1:0]  baud_reduction;
      logic [LIMIT_W-1:0] reset_retry_limit;
      logic [LIMIT_W-1:0] voltage_retry_limit;
      logic [LIMIT_W-1:0] ready_retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FRAME_W-1:0] command_frame;
      logic               expects_trailer;
      logic [BAUD_W-1:0]  clock_divisor;
   } rsp_type;

   // frame with crc7 over the five leading bytes, msb first
   function automatic logic [FRAME_W-1:0] make_frame(input logic [5:0] index,
                                                     input logic [31:0] arg);
      logic [39:0] msg;
      logic [6:0]  crc;
      logic        fb;
      msg = {2'b01, index, arg};
      crc = '0;
      for (int i = 39; i >= 0; i--) begin
         fb  = crc[6] ^ msg[i];
         crc = {crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
      end
      return {msg, crc, 1'b1};
   endfunction

   localparam logic [FRAME_W-1:0] FRAME_CMD0   = make_frame(6'd0, 32'd0);
   localparam logic [FRAME_W-1:0] FRAME_CMD8   = make_frame(6'd8, VHS_PATTERN);
   localparam logic [FRAME_W-1:0] FRAME_CMD59  = make_frame(6'd59, 32'd1);
   localparam logic [FRAME_W-1:0] FRAME_CMD55  = make_frame(6'd55, 32'd0);
   localparam logic [FRAME_W-1:0] FRAME_ACMD41 = make_frame(6'd41, HCS_ARG);
   localparam logic [FRAME_W-1:0] FRAME_CMD58  = make_frame(6'd58, 32'd0);
   localparam logic [FRAME_W-1:0] FRAME_CMD16  = make_frame(6'd16, BLOCK_LENGTH);

endpackage

FILE: design/sdinit_step.sv
// ----------------------------------------------------------------------------
// sdinit_step
// init phase tracking, retry counting and result formation for one beat
// ----------------------------------------------------------------------------
`include "sd_spi_init_sequencer_macros.svh"

module sdinit_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic                             mode,
   input  logic [7:0]                       r1_byte,
   input  logic [sdinit_pkg::TRAILER_W-1:0] trailer_word,
   input  sdinit_pkg::cfg_type              cfg,
   output sdinit_pkg::rsp_type              rsp
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_CMD0, PH_CMD8, PH_CMD59, PH_CMD55, PH_ACMD41, PH_CMD58, PH_CMD16
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [sdinit_pkg::COUNT_W-1:0]     count_ff, count_in, count_inc;
   logic                               fast_ff, fast_in;
   logic                               do_issue, do_retry, retry_fail;
   phase_type                          issue_ph;
   logic [sdinit_pkg::LIMIT_W-1:0]     retry_limit;
   logic [1:0]                         finish_status;
   logic [sdinit_pkg::BAUD_W-1:0]      fast_div;
   logic                               r1_bad;

   assign count_inc = count_ff + 1'b1;
   assign r1_bad    = r1_byte > sdinit_pkg::R1_IDLE;
   assign fast_div  = (cfg.baud_reduction == '1) ? '1 : cfg.baud_reduction + 1'b1;
   assign retry_fail = count_inc > {1'b0, retry_limit};

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      fast_in       = fast_ff;
      do_issue      = 1'b0;
      do_retry      = 1'b0;
      issue_ph      = PH_CMD0;
      retry_limit   = cfg.reset_retry_limit;
      finish_status = sdinit_pkg::STATUS_IGNORED;

      if (mode == sdinit_pkg::MODE_START) begin
         count_in = '0;
         fast_in  = 1'b0;
         do_issue = 1'b1;
         issue_ph = PH_CMD0;
      end else begin
         unique case (phase_ff)
            PH_CMD0: begin
               if (r1_byte == sdinit_pkg::R1_IDLE) begin
                  count_in = '0;
                  do_issue = 1'b1;
                  issue_ph = PH_CMD8;
               end else begin
                  do_retry = 1'b1;
                  issue_ph = PH_CMD0;
               end
            end
            PH_CMD8: begin
               retry_limit = cfg.voltage_retry_limit;
               if (r1_byte == sdinit_pkg::R1_IDLE && trailer_word == sdinit_pkg::VHS_PATTERN) begin
                  do_issue = 1'b1;
                  issue_ph = PH_CMD59;
               end else begin
                  do_retry = 1'b1;
                  issue_ph = PH_CMD8;
               end
            end
            PH_CMD59: begin
               if (r1_bad) begin
                  finish_status = sdinit_pkg::STATUS_FAIL;
               end else begin
                  count_in = '0;
                  do_issue = 1'b1;
                  issue_ph = PH_CMD55;
               end
            end
            PH_CMD55: begin
               retry_limit = cfg.ready_retry_limit;
               issue_ph    = r1_bad ? PH_CMD55 : PH_ACMD41;
               do_retry    = r1_bad;
               do_issue    = !r1_bad;
            end
            PH_ACMD41: begin
               retry_limit = cfg.ready_retry_limit;
               if (r1_byte == 8'h00) begin
                  fast_in  = 1'b1;
                  do_issue = 1'b1;
                  issue_ph = PH_CMD58;
               end else begin
                  do_retry = 1'b1;
                  issue_ph = PH_CMD55;
               end
            end
            PH_CMD58: begin
               if (r1_bad) begin
                  finish_status = sdinit_pkg::STATUS_FAIL;
               end else begin
                  do_issue = 1'b1;
                  issue_ph = PH_CMD16;
               end
            end
            PH_CMD16: begin
               finish_status = r1_bad ? sdinit_pkg::STATUS_FAIL : sdinit_pkg::STATUS_DONE;
            end
            PH_IDLE: begin
               finish_status = sdinit_pkg::STATUS_IGNORED;
            end
         endcase
      end

      // a failed attempt either retries or ends the init
      if (do_retry) begin
         count_in = count_inc;
         if (retry_fail) begin
            finish_status = sdinit_pkg::STATUS_FAIL;
         end else begin
            do_issue = 1'b1;
         end
      end

      phase_in = do_issue ? issue_ph : PH_IDLE;

      rsp.clock_divisor   = fast_in ? fast_div : sdinit_pkg::SLOW_DIVISOR;
      rsp.status          = do_issue ? sdinit_pkg::STATUS_SEND : finish_status;
      rsp.command_frame   = '0;
      rsp.expects_trailer = 1'b0;
      if (do_issue) begin
         unique case (issue_ph)
            PH_CMD0:   rsp.command_frame = sdinit_pkg::FRAME_CMD0;
            PH_CMD8: begin
               rsp.command_frame   = sdinit_pkg::FRAME_CMD8;
               rsp.expects_trailer = 1'b1;
            end
            PH_CMD59:  rsp.command_frame = sdinit_pkg::FRAME_CMD59;
            PH_CMD55:  rsp.command_frame = sdinit_pkg::FRAME_CMD55;
            PH_ACMD41: rsp.command_frame = sdinit_pkg::FRAME_ACMD41;
            PH_CMD58: begin
               rsp.command_frame   = sdinit_pkg::FRAME_CMD58;
               rsp.expects_trailer = 1'b1;
            end
            PH_CMD16:  rsp.command_frame = sdinit_pkg::FRAME_CMD16;
            PH_IDLE:   rsp.command_frame = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         fast_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         fast_ff  <= fast_in;
      end
   end

   // a failure past the limit ends the loop, so the count never goes past limit + 1
   `SDI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   count_ff <= (sdinit_pkg::COUNT_W)'(13'd4096))
   `SDI_ASSERT_NEXT(a_start_restarts, clock, reset, fire && mode == sdinit_pkg::MODE_START,
                    phase_ff == PH_CMD0 && count_ff == '0 && !fast_ff)
   `SDI_ASSERT_NEXT(a_fast_from_acmd41, clock, reset, !fast_ff,
                    !fast_ff || $past(phase_ff) == PH_ACMD41)

endmodule

FILE: design/sd_spi_init_sequencer.sv
// SD card SPI-mode init sequencer. A beat with mode 0 starts (or restarts) the
// sequence and answers with the CMD0 frame; each later beat carries the card's
// R1 and trailer for the last command and answers with the next frame or with
// a done / fail status. Throughput is one beat per clock while rsp_ready is
// high; each beat passes the input register, then the result register, where
// phase, retry count and clock select are updated. The input register, when
// empty, takes a new beat while a result still waits on rsp_ready. Registers
// are written with csr_we and must be changed only while no beat is in flight.
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// top level: csr bank, input register, result register and step logic
// ----------------------------------------------------------------------------
`include "sd_spi_init_sequencer_macros.svh"

module sd_spi_init_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [7:0]                          req_r1_byte,
   input  logic [sdinit_pkg::TRAILER_W-1:0]    req_trailer_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [sdinit_pkg::FRAME_W-1:0]      rsp_command_frame,
   output logic                                rsp_expects_trailer,
   output logic [sdinit_pkg::BAUD_W-1:0]       rsp_clock_divisor,
   input  logic                                csr_we,
   input  logic [sdinit_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdinit_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sdinit_pkg::cfg_type               cfg_ff;
   logic                              in_valid_ff;
   logic                              in_mode_ff;
   logic [7:0]                        in_r1_ff;
   logic [sdinit_pkg::TRAILER_W-1:0]  in_trailer_ff;
   logic                              out_valid_ff;
   sdinit_pkg::rsp_type               out_rsp_ff, out_rsp_in;
   logic                              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baud_reduction      <= sdinit_pkg::BAUD_RESET;
         cfg_ff.reset_retry_limit   <= sdinit_pkg::RESET_LIMIT_RESET;
         cfg_ff.voltage_retry_limit <= sdinit_pkg::VOLTAGE_LIMIT_RESET;
         cfg_ff.ready_retry_limit   <= sdinit_pkg::READY_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sdinit_pkg::CSR_BAUD_REDUCTION:
               cfg_ff.baud_reduction <= csr_wdata[sdinit_pkg::BAUD_W-1:0];
            sdinit_pkg::CSR_RESET_LIMIT:   cfg_ff.reset_retry_limit   <= csr_wdata;
            sdinit_pkg::CSR_VOLTAGE_LIMIT: cfg_ff.voltage_retry_limit <= csr_wdata;
            sdinit_pkg::CSR_READY_LIMIT:   cfg_ff.ready_retry_limit   <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff    <= req_mode;
         in_r1_ff      <= req_r1_byte;
         in_trailer_ff <= req_trailer_word;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   sdinit_step u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .mode         (in_mode_ff),
      .r1_byte      (in_r1_ff),
      .trailer_word (in_trailer_ff),
      .cfg          (cfg_ff),
      .rsp          (out_rsp_in)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_rsp_ff.status;
   assign rsp_command_frame   = out_rsp_ff.command_frame;
   assign rsp_expects_trailer = out_rsp_ff.expects_trailer;
   assign rsp_clock_divisor   = out_rsp_ff.clock_divisor;

   // only a command beat carries a frame
   `SDI_ASSERT_NOW(a_frame_only_on_send, clock, reset,
                   out_valid_ff && out_rsp_ff.status != sdinit_pkg::STATUS_SEND,
                   out_rsp_ff.command_frame == '0 && !out_rsp_ff.expects_trailer)
   `SDI_ASSERT_NOW(a_ready_low_only_when_full, clock, reset, !req_ready,
                   in_valid_ff && out_valid_ff && !rsp_ready)
   `SDI_ASSERT_NEXT(a_input_held_when_stalled, clock, reset, in_valid_ff && !advance,
                    in_valid_ff && $stable(in_r1_ff) && $stable(in_mode_ff))

endmodule
